FILE: rtl/reference_count_table_defines.svh
// Assertion macros for the reference count table.
// Define SYNTH to compile them away.
`ifndef REFERENCE_COUNT_TABLE_DEFINES_SVH
`define REFERENCE_COUNT_TABLE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset.
`define RCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rct assertion failed");

// Next-cycle implication, disabled while in reset.
`define RCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rct assertion failed");

`else

`define RCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define RCT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/rct_pkg.sv
package rct_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

  localparam int ACT_W    = 3;
  localparam int IDENT_W  = 32;
  localparam int ADDR_W   = 48;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [ACT_W-1:0] ACT_CREATE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INC    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEC    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ADDR   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = -16'sh8000;
  localparam logic signed [COUNT_W-1:0] COUNT_ONE = 16'sd1;

  // One table slot.
  typedef struct packed {
    logic                      valid;
    logic signed [IDENT_W-1:0] ident;
    logic [ADDR_W-1:0]         addr;
    logic signed [COUNT_W-1:0] count;
  } entry_t;

  // Request token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic                      valid;
    logic [ACT_W-1:0]          act;
    logic signed [IDENT_W-1:0] ident;
    logic [ADDR_W-1:0]         addr;
    logic                      hit;
    logic signed [COUNT_W-1:0] cnt;
  } token_t;

endpackage

FILE: rtl/reference_count_table.sv
// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------
// in      | in_valid, in_stall  | action, ident, new_address
// out     | out_valid, out_stall| status, ref_count, entry_count
//
// An accepted beat becomes a token that walks the cell chain, one cell per
// cycle; the token leaving the last cell loads the registered result beat.
// One request is in flight at a time: in_stall stays high until the result
// beat is taken.
// Reset (rst, synchronous) empties the table, drops any token and result.
// A stalled result beat holds on out until out_stall falls.
`include "reference_count_table_defines.svh"

module reference_count_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rct_pkg::ACT_W-1:0]           action,
  input  logic signed [rct_pkg::IDENT_W-1:0]  ident,
  input  logic [rct_pkg::ADDR_W-1:0]          new_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rct_pkg::STATUS_W-1:0]        status,
  output logic signed [rct_pkg::COUNT_W-1:0]  ref_count,
  output logic [rct_pkg::USED_W-1:0]          entry_count
);

  localparam int N = rct_pkg::TABLE_ENTRIES;

  // tok[k] feeds cell k; tok[N] leaves the last cell.
  rct_pkg::token_t tok [N+1];
  // ent[k] is the slot held by cell k; ent[N] is an always-empty slot.
  rct_pkg::entry_t ent [N+1];

  logic                              busy;
  logic                              in_take;
  logic                              out_take;
  logic [rct_pkg::USED_W-1:0]        used;
  logic [rct_pkg::USED_W-1:0]        used_next;
  logic [rct_pkg::STATUS_W-1:0]      status_next;
  logic [N:0]                        tok_live;

  // Hold off new requests while one is in the chain or waiting on out.
  assign in_stall = busy;
  assign in_take  = in_valid && !busy;
  assign out_take = out_valid && !out_stall;

  // Launch the token straight into cell 0 on the accepting edge.
  always_comb begin
    tok[0].valid = in_take;
    tok[0].act   = action;
    tok[0].ident = ident;
    tok[0].addr  = new_address;
    tok[0].hit   = 1'b0;
    tok[0].cnt   = '0;
  end

  assign ent[N] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    rct_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok[g]),
      .tok_out   (tok[g+1]),
      .right_ent (ent[g+1]),
      .ent       (ent[g])
    );
  end

  always_comb begin
    for (int k = 0; k <= N; k++) begin
      tok_live[k] = tok[k].valid;
    end
  end

  // Fold the token's outcome into status and the entry count.
  always_comb begin
    used_next   = used;
    status_next = rct_pkg::ST_OK;
    unique case (tok[N].act)
      rct_pkg::ACT_CREATE: begin
        if (tok[N].hit) begin
          used_next = used + rct_pkg::USED_W'(1);
        end else begin
          status_next = rct_pkg::ST_FULL;
        end
      end
      rct_pkg::ACT_DELETE: begin
        if (tok[N].hit) begin
          used_next = used - rct_pkg::USED_W'(1);
        end else begin
          status_next = rct_pkg::ST_NOTFOUND;
        end
      end
      rct_pkg::ACT_INC, rct_pkg::ACT_DEC, rct_pkg::ACT_ADDR, rct_pkg::ACT_QUERY: begin
        if (!tok[N].hit) begin
          status_next = rct_pkg::ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Control: busy from accept until the result beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      used      <= '0;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
      end else if (out_take) begin
        busy <= 1'b0;
      end
      if (tok[N].valid) begin
        out_valid <= 1'b1;
        used      <= used_next;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load when the token drops out of the chain, hold otherwise.
  always_ff @(posedge clk) begin
    if (tok[N].valid) begin
      status      <= status_next;
      ref_count   <= tok[N].cnt;
      entry_count <= used_next;
    end
  end

  `RCT_ASSERT_IMP(a_one_token, clk, rst, 1'b1, $onehot0(tok_live))
  `RCT_ASSERT_IMP(a_used_bound, clk, rst, 1'b1, used <= rct_pkg::USED_W'(N))
  `RCT_ASSERT_NEXT(a_token_lands, clk, rst, tok[N].valid, out_valid && busy)
  `RCT_ASSERT_IMP(a_full_count, clk, rst, out_valid && status == rct_pkg::ST_FULL, entry_count == rct_pkg::USED_W'(N) && ref_count == '0)
  `RCT_ASSERT_IMP(a_missing_zero, clk, rst, out_valid && status == rct_pkg::ST_NOTFOUND, ref_count == '0)

endmodule

FILE: rtl/rct_cell.sv
module rct_cell (
  input  logic            clk,
  input  logic            rst,
  input  rct_pkg::token_t tok_in,
  output rct_pkg::token_t tok_out,
  input  rct_pkg::entry_t right_ent,
  output rct_pkg::entry_t ent
);

  rct_pkg::token_t tok_next;
  rct_pkg::entry_t ent_next;
  logic            match;

  assign match = ent.valid && (ent.ident == tok_in.ident);

  always_comb begin
    tok_next = tok_in;
    ent_next = ent;
    if (tok_in.valid) begin
      unique case (tok_in.act)
        rct_pkg::ACT_CREATE: begin
          // first free slot takes the new entry
          if (!tok_in.hit && !ent.valid) begin
            ent_next.valid = 1'b1;
            ent_next.ident = tok_in.ident;
            ent_next.addr  = tok_in.addr;
            ent_next.count = rct_pkg::COUNT_ONE;
            tok_next.hit   = 1'b1;
            tok_next.cnt   = rct_pkg::COUNT_ONE;
          end
        end
        rct_pkg::ACT_INC, rct_pkg::ACT_DEC, rct_pkg::ACT_QUERY: begin
          if (!tok_in.hit && match) begin
            if (tok_in.act == rct_pkg::ACT_INC && ent.count != rct_pkg::COUNT_MAX) begin
              ent_next.count = ent.count + rct_pkg::COUNT_ONE;
            end else if (tok_in.act == rct_pkg::ACT_DEC &&
                         ent.count != rct_pkg::COUNT_MIN) begin
              ent_next.count = ent.count - rct_pkg::COUNT_ONE;
            end
            tok_next.hit = 1'b1;
            tok_next.cnt = ent_next.count;
          end
        end
        rct_pkg::ACT_DELETE: begin
          // from the oldest match on, pull the right neighbor down one slot
          if (tok_in.hit || match) begin
            ent_next     = right_ent;
            tok_next.hit = 1'b1;
          end
        end
        rct_pkg::ACT_ADDR: begin
          if (match) begin
            ent_next.addr = tok_in.addr;
            if (!tok_in.hit) begin
              tok_next.hit = 1'b1;
              tok_next.cnt = ent.count;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      ent.valid     <= 1'b0;
    end else begin
      tok_out <= tok_next;
      ent     <= ent_next;
    end
  end

endmodule
